>>> rtl/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared widths, character codes, sequencer states and control types for the
// integer to decimal ASCII core.
// ----------------------------------------------------------------------------
package i2da_pkg;

   // Width of the signed input value.
   localparam int WIDTH = 32;

   // Byte-padded width of the request data bus.
   localparam int REQ_TDATA_W = ((WIDTH + 7) / 8) * 8;

   // Character width and byte-padded response data width.
   localparam int CHAR_W      = 6;
   localparam int RSP_TDATA_W = ((CHAR_W + 7) / 8) * 8;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

   // Number of decimal digits in the largest magnitude, 2^(WIDTH-1).
   function automatic int num_digits();
      logic [63:0] v;
      int          n;
      v = 64'd1 << (WIDTH - 1);
      n = 0;
      for (int i = 0; i < 21; i++) begin
         if (v != 64'd0) begin
            n = n + 1;
            v = v / 64'd10;
         end
      end
      return n;
   endfunction

   localparam int NDIG   = num_digits();
   localparam int BCD_W  = NDIG * 4;
   localparam int SCNT_W = $clog2(WIDTH);
   localparam int DCNT_W = $clog2(NDIG + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   // Commands from the sequencer to the conversion unit.
   typedef struct packed {
      logic load;         // take a new magnitude, clear the digits
      logic step;         // one add-3 and shift iteration
      logic shift_digit;  // drop the top digit, move the next one up
   } dabble_ctrl_type;

endpackage

>>> rtl/i2da_dabble.sv
// ----------------------------------------------------------------------------
// i2da_dabble
// Iterative binary to BCD unit (shift and add-3). One bit of the magnitude
// enters the digit register per step; afterwards the digits are shifted out
// from the most significant end one at a time.
// ----------------------------------------------------------------------------
module i2da_dabble
   import i2da_pkg::*;
(
   input  logic             clock,
   input  dabble_ctrl_type  ctrl,
   input  logic [WIDTH-1:0] magnitude,
   output logic [3:0]       top_digit
);

   logic [BCD_W-1:0] bcd_ff;
   logic [BCD_W-1:0] bcd_in;
   logic [WIDTH-1:0] bin_ff;
   logic [WIDTH-1:0] bin_in;
   logic [BCD_W-1:0] bcd_adj;

   // Every digit of five or more is corrected before the shift doubles it.
   always_comb begin
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      if (ctrl.load) begin
         bcd_in = '0;
         bin_in = magnitude;
      end else if (ctrl.step) begin
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[WIDTH-1]};
         bin_in = {bin_ff[WIDTH-2:0], 1'b0};
      end else if (ctrl.shift_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

>>> rtl/integer_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_core
// Formats one signed integer as decimal ASCII text, one character per
// response, most significant first, with tlast on the final character.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   req_     in         tdata: value (WIDTH bits, signed)
//   rsp_     out        tdata: character (6 bits); tlast: last character
//
// A request passes through an accept in idle, WIDTH shift-and-add-3 steps in the
// BCD unit, a skip state that drops the leading zero digits one at a time and
// finds the first digit, a minus sign for a negative value, then the digits.
// req_tready is high only while idle. A stalled response holds the sequencer.
// Synchronous reset returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_core
   import i2da_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [WIDTH-1:0] value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [5:0] character
   output logic                   rsp_tlast
);

   state_type             state_ff;
   state_type             state_in;
   logic [SCNT_W-1:0]     step_cnt_ff;
   logic [SCNT_W-1:0]     step_cnt_in;
   logic [DCNT_W-1:0]     digit_cnt_ff;
   logic [DCNT_W-1:0]     digit_cnt_in;
   logic                  negative_ff;
   logic                  negative_in;
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [CHAR_W-1:0]     rsp_char_ff;
   logic [CHAR_W-1:0]     rsp_char_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;

   dabble_ctrl_type       ctrl;
   logic [WIDTH-1:0]      raw;
   logic [WIDTH-1:0]      magnitude;
   logic [3:0]            top_digit;
   logic                  req_fire;
   logic                  out_free;
   logic                  final_digit;

   assign raw         = req_tdata[WIDTH-1:0];
   assign magnitude   = raw[WIDTH-1] ? WIDTH'(~raw + WIDTH'(1)) : raw;
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign final_digit = (digit_cnt_ff == DCNT_W'(1));

   i2da_dabble u_dabble (
      .clock     (clock),
      .ctrl      (ctrl),
      .magnitude (magnitude),
      .top_digit (top_digit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (step_cnt_ff == '0) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!(top_digit == 4'd0 && !final_digit)) begin
               state_in = negative_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (out_free && final_digit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs, counters and the response register.
   always_comb begin
      ctrl          = '0;
      step_cnt_in   = step_cnt_ff;
      digit_cnt_in  = digit_cnt_ff;
      negative_in   = negative_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ctrl.load   = 1'b1;
               negative_in = raw[WIDTH-1];
               step_cnt_in = SCNT_W'(WIDTH - 1);
            end
         end
         ST_CONVERT: begin
            ctrl.step   = 1'b1;
            step_cnt_in = step_cnt_ff - SCNT_W'(1);
            if (step_cnt_ff == '0) digit_cnt_in = DCNT_W'(NDIG);
         end
         ST_SKIP: begin
            // Leading zeros are dropped, but the units digit always stays.
            if (top_digit == 4'd0 && !final_digit) begin
               ctrl.shift_digit = 1'b1;
               digit_cnt_in     = digit_cnt_ff - DCNT_W'(1);
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = ASCII_MINUS;
               rsp_last_in   = 1'b0;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_tvalid_in    = 1'b1;
               rsp_char_in      = ASCII_ZERO + {2'b00, top_digit};
               rsp_last_in      = final_digit;
               ctrl.shift_digit = 1'b1;
               digit_cnt_in     = digit_cnt_ff - DCNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_cnt_ff  <= step_cnt_in;
      digit_cnt_ff <= digit_cnt_in;
      negative_ff  <= negative_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_char_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> tb/sv/decimal_text_checker.sv
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches the request and response streams of the integer to decimal ASCII
// core, predicts the decimal text of every accepted value and compares each
// accepted character and its tlast flag against the oldest prediction.
// ----------------------------------------------------------------------------
module decimal_text_checker
   import i2da_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [WIDTH-1:0] value
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // [5:0] character
   input  logic                   rsp_tlast,
   output int                     mismatch_count,
   output int                     pending_chars,
   output int                     values_seen,
   output int                     chars_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } text_char_type;

   text_char_type expected_text[$];

   // Queues the characters of one value, sign first, most significant digit
   // next. The magnitude is taken as an unsigned WIDTH-bit quantity, which
   // keeps the most negative value exact.
   function automatic void queue_decimal_text(input logic [WIDTH-1:0] value);
      logic [WIDTH-1:0] magnitude;
      logic [3:0]       digits[21];
      int               count;
      text_char_type    next_char;
      magnitude = value[WIDTH-1] ? (~value + 1'b1) : value;
      count = 0;
      do begin
         digits[count] = 4'(magnitude % 10);
         count++;
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[WIDTH-1]) begin
         next_char.character = ASCII_MINUS;
         next_char.last      = 1'b0;
         expected_text.push_back(next_char);
      end
      for (int k = count - 1; k >= 0; k--) begin
         next_char.character = CHAR_W'(ASCII_ZERO + digits[k]);
         next_char.last      = (k == 0);
         expected_text.push_back(next_char);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type oldest;
      if (reset) begin
         mismatch_count <= 0;
         pending_chars  <= 0;
         values_seen    <= 0;
         chars_seen     <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            queue_decimal_text(req_tdata[WIDTH-1:0]);
            values_seen <= values_seen + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            chars_seen <= chars_seen + 1;
            if (expected_text.size() == 0) begin
               $error("unexpected character: actual %0d, last %0b",
                      rsp_tdata[CHAR_W-1:0], rsp_tlast);
               mismatch_count <= mismatch_count + 1;
            end else begin
               oldest = expected_text.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== oldest.character) begin
                  $error("character: expected %0d, actual %0d",
                         oldest.character, rsp_tdata[CHAR_W-1:0]);
                  mismatch_count <= mismatch_count + 1;
               end else if (rsp_tlast !== oldest.last) begin
                  $error("last: expected %0b, actual %0b", oldest.last, rsp_tlast);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         pending_chars <= expected_text.size();
      end
   end

endmodule

>>> tb/sv/integer_to_decimal_ascii_core_tb.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_core_tb
// Drives signed values into the integer to decimal ASCII core: edge cases
// first, then random values of every magnitude, with random stalls on both
// streams and one long response hold-off. A separate checker predicts and
// compares the text; this module gives the verdict.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_core_tb
   import i2da_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_VALUES = 80;
   localparam int QUIET_VALUES  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int TAIL_CYCLES   = 70;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;    // [WIDTH-1:0] value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // [5:0] character
   logic                   rsp_tlast;

   int mismatch_count;
   int pending_chars;
   int values_seen;
   int chars_seen;
   int idle_cycles = 0;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;
   bit quiet        = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   integer_to_decimal_ascii_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   decimal_text_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_chars  (pending_chars),
      .values_seen    (values_seen),
      .chars_seen     (chars_seen)
   );

   // Offers one request and waits for it to be taken, then idles for a
   // random burst now and then.
   task automatic send_value(input logic [WIDTH-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(value);
      do @(posedge clock); while (!req_tready);
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'($urandom);
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Random magnitude spread over all sizes, random sign.
   function automatic logic [WIDTH-1:0] random_value();
      logic [WIDTH-1:0] value;
      value = WIDTH'($urandom) >> $urandom_range(0, WIDTH - 1);
      if ($urandom_range(0, 1) == 1)
         value = ~value + 1'b1;
      return value;
   endfunction

   initial begin
      logic [WIDTH-1:0] edge_values[$];
      edge_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd9, -32'sd10,
                      32'sd99, 32'sd100, 32'sd12345, -32'sd67890,
                      32'sd999999999, 32'sd1000000000, -32'sd1000000000,
                      32'sd2147483647, -32'sd2147483647, 32'h8000_0000,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (edge_values[i])
         send_value(edge_values[i]);
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         if (i == 25)
            hold_request = 1'b1;
         if (i == RANDOM_VALUES - QUIET_VALUES)
            quiet = 1'b1;
         send_value(random_value());
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_chars != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d values formatted into %0d characters, edge values and random sizes,",
               values_seen, chars_seen);
      $display("with random stalls on both sides and a %0d-cycle response hold-off.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_chars == 0 && hold_done)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Response side: random ready bursts, one long hold-off while the sender
   // keeps offering, and a steady ready in the quiet tail.
   initial begin
      @(negedge reset);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Ends the run when neither stream moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
